@@ rtl/sdec_pkg.sv @@
// ----------------------------------------------------------------------------
// Six-bit text decoder package
// Result kinds, status codes, character codes and the result record that the
// decoder and its output stages share.
// ----------------------------------------------------------------------------
package sdec_pkg;

  // Width of the decoded byte counter and the limit register.
  localparam int unsigned CountWidth = 29;

  // Limit after reset: 2^28 decoded bytes.
  localparam logic [CountWidth-1:0] LimitReset = 29'h1000_0000;

  // Character codes of the encoded text.
  localparam logic [7:0] ChLf     = 8'h0a;
  localparam logic [7:0] ChCr     = 8'h0d;
  localparam logic [7:0] ChEsc    = 8'h7e;
  localparam logic [7:0] AlphaLo  = 8'h30;
  localparam logic [7:0] AlphaHi  = 8'h6f;
  localparam logic [7:0] CountHi  = 8'h7e;
  localparam logic [6:0] GroupLen = 7'd3;

  // Input request types.
  typedef enum logic {
    REQ_BODY = 1'b0,
    REQ_END  = 1'b1
  } req_e;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_GROUP  = 2'd0,
    KIND_RUN    = 2'd1,
    KIND_STATUS = 2'd2
  } kind_e;

  // Final status codes.
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BADCHAR  = 3'd1,
    ST_ESCBREAK = 3'd2,
    ST_BADCOUNT = 3'd3,
    ST_LIMIT    = 3'd4,
    ST_TRUNC    = 3'd5,
    ST_EMPTY    = 3'd6
  } status_e;

  // One result item as it moves through the output stages.
  typedef struct packed {
    kind_e                 kind;
    logic [7:0]            byte_high;
    logic [7:0]            byte_mid;
    logic [7:0]            byte_low;
    logic [6:0]            run_length;
    status_e               status;
    logic [CountWidth-1:0] raw_size;
    logic [1:0]            strip_count;
  } result_t;

endpackage

@@ rtl/six_bit_text_to_binary_decoder.sv @@
// ----------------------------------------------------------------------------
// Six-bit text to binary decoder
// Decodes the body of a six-bit text encoding into groups of three bytes and
// runs of NUL bytes, and reports a final status at the end of each body.
// ----------------------------------------------------------------------------
//
// Usage:
//   The input channel (in_valid_i / in_stall_o) carries one body character or
//   an end-of-body marker per transfer. The output channel (out_valid_o /
//   out_stall_i) carries at most one result per input transfer: a decoded
//   group of three bytes, a NUL run length, or the final status record.
//   The limit register is written through cfg_we_i / cfg_wdata_i; the user
//   must write it only while the block is idle: the block does not enforce it.
//
//   A result is registered into the output register at the edge of its input
//   transfer, or into the skid register while the output register stalls.
//   Throughput is one item per cycle while in_stall_o is low; the decode, the
//   limit add and compare and the state update all finish in the transfer cycle.
//
//   Reset clears the decoder state and sets the limit to 2^28 bytes.
//   When the receiver stalls, the output register holds its result and a
//   skid register takes one more; in_stall_o rises only when both are full.
//
module six_bit_text_to_binary_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration
  input  logic        cfg_we_i,
  input  logic [28:0] cfg_wdata_i,
  // Input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        req_type_i,
  input  logic [7:0]  byte_value_i,
  // Output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  byte_high_o,
  output logic [7:0]  byte_mid_o,
  output logic [7:0]  byte_low_o,
  output logic [6:0]  run_length_o,
  output logic [2:0]  status_o,
  output logic [28:0] raw_size_o,
  output logic [1:0]  strip_count_o
);

  localparam int unsigned CW = sdec_pkg::CountWidth;

  // Decoder state.
  logic [CW-1:0]       limit_q;
  logic [1:0]          fill_q, fill_d;
  logic [5:0]          gval_q [3];
  logic [5:0]          gval_d [3];
  logic                esc_q, esc_d;
  logic [CW-1:0]       count_q, count_d;
  logic [1:0]          tnul_q, tnul_d;
  sdec_pkg::status_e   err_q, err_d;

  // Output stages.
  sdec_pkg::result_t   out_q, skid_q, res_d;
  logic                out_valid_q, skid_valid_q;
  logic                res_valid;

  logic                in_xfer;
  logic                out_ready;

  // Decode helpers.
  logic [7:0]          chr;
  logic [5:0]          val;
  logic [6:0]          run;
  logic [6:0]          add_amt;
  logic [CW:0]         sum;
  logic                over;
  logic [7:0]          tnul_sum;
  logic [7:0]          b0, b1, b2;
  logic [1:0]          strip;

  assign in_stall_o = skid_valid_q;
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_ready  = !out_valid_q || !out_stall_i;

  assign chr      = byte_value_i;
  assign val      = 6'(chr - sdec_pkg::AlphaLo);
  assign run      = 7'(chr - sdec_pkg::AlphaLo);
  assign add_amt  = esc_q ? run : sdec_pkg::GroupLen;
  assign sum      = {1'b0, count_q} + {{(CW-6){1'b0}}, add_amt};
  assign over     = sum > {1'b0, limit_q};
  assign tnul_sum = {6'b0, tnul_q} + {1'b0, run};

  // Bytes of a completed group, most significant bits first.
  assign b0 = {gval_q[0], gval_q[1][5:4]};
  assign b1 = {gval_q[1][3:0], gval_q[2][5:2]};
  assign b2 = {gval_q[2][1:0], val};

  assign strip = tnul_q;

  // Next state and result for the item in transfer.
  always_comb begin
    fill_d    = fill_q;
    gval_d    = gval_q;
    esc_d     = esc_q;
    count_d   = count_q;
    tnul_d    = tnul_q;
    err_d     = err_q;
    res_valid = 1'b0;
    res_d     = '0;
    res_d.kind   = sdec_pkg::KIND_GROUP;
    res_d.status = sdec_pkg::ST_OK;

    if (in_xfer) begin
      if (req_type_i == sdec_pkg::REQ_END) begin
        // End of body: report and return to the initial state.
        res_valid    = 1'b1;
        res_d.kind   = sdec_pkg::KIND_STATUS;
        res_d.status = err_q;
        if (err_q == sdec_pkg::ST_OK) begin
          if (esc_q || fill_q != 2'd0) begin
            res_d.status = sdec_pkg::ST_TRUNC;
          end else if (count_q <= {{(CW-2){1'b0}}, strip}) begin
            res_d.status = sdec_pkg::ST_EMPTY;
          end else begin
            res_d.raw_size    = count_q;
            res_d.strip_count = strip;
          end
        end
        fill_d  = 2'd0;
        esc_d   = 1'b0;
        count_d = '0;
        tnul_d  = 2'd0;
        err_d   = sdec_pkg::ST_OK;
      end else if (err_q != sdec_pkg::ST_OK) begin
        // Sticky error: body bytes are dropped until the end marker.
      end else if (chr == sdec_pkg::ChLf || chr == sdec_pkg::ChCr) begin
        if (esc_q) begin
          err_d = sdec_pkg::ST_ESCBREAK;
        end
      end else if (esc_q) begin
        // Count character after an escape.
        esc_d = 1'b0;
        if (chr < sdec_pkg::AlphaLo || chr > sdec_pkg::CountHi) begin
          err_d = sdec_pkg::ST_BADCOUNT;
        end else if (run == 7'd0) begin
          // An empty run gives nothing.
        end else if (over) begin
          err_d = sdec_pkg::ST_LIMIT;
        end else begin
          count_d          = sum[CW-1:0];
          tnul_d           = (tnul_sum > 8'd2) ? 2'd2 : tnul_sum[1:0];
          res_valid        = 1'b1;
          res_d.kind       = sdec_pkg::KIND_RUN;
          res_d.run_length = run;
        end
      end else if (chr == sdec_pkg::ChEsc) begin
        esc_d = 1'b1;
      end else if (chr < sdec_pkg::AlphaLo || chr > sdec_pkg::AlphaHi) begin
        err_d = sdec_pkg::ST_BADCHAR;
      end else if (fill_q != 2'd3) begin
        gval_d[fill_q] = val;
        fill_d         = fill_q + 2'd1;
      end else begin
        // Fourth character completes the group.
        fill_d = 2'd0;
        if (over) begin
          err_d = sdec_pkg::ST_LIMIT;
        end else begin
          count_d = sum[CW-1:0];
          if (b2 != 8'd0) begin
            tnul_d = 2'd0;
          end else if (b1 != 8'd0) begin
            tnul_d = 2'd1;
          end else begin
            tnul_d = 2'd2;
          end
          res_valid       = 1'b1;
          res_d.kind      = sdec_pkg::KIND_GROUP;
          res_d.byte_high = b0;
          res_d.byte_mid  = b1;
          res_d.byte_low  = b2;
        end
      end
    end
  end

  // Control state and the limit register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= sdec_pkg::LimitReset;
      fill_q  <= 2'd0;
      esc_q   <= 1'b0;
      count_q <= '0;
      tnul_q  <= 2'd0;
      err_q   <= sdec_pkg::ST_OK;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      fill_q  <= fill_d;
      esc_q   <= esc_d;
      count_q <= count_d;
      tnul_q  <= tnul_d;
      err_q   <= err_d;
    end
  end

  // Group values are written before they are read; no reset needed.
  always_ff @(posedge clk_i) begin
    gval_q <= gval_d;
  end

  // Output register with a skid register behind it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (out_ready) begin
        if (skid_valid_q) begin
          out_valid_q  <= 1'b1;
          skid_valid_q <= 1'b0;
        end else begin
          out_valid_q <= res_valid;
        end
      end else if (res_valid) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  // Payload of the output stages.
  always_ff @(posedge clk_i) begin
    if (out_ready) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (res_valid) begin
        out_q <= res_d;
      end
    end else if (res_valid) begin
      skid_q <= res_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign kind_o        = out_q.kind;
  assign byte_high_o   = out_q.byte_high;
  assign byte_mid_o    = out_q.byte_mid;
  assign byte_low_o    = out_q.byte_low;
  assign run_length_o  = out_q.run_length;
  assign status_o      = out_q.status;
  assign raw_size_o    = out_q.raw_size;
  assign strip_count_o = out_q.strip_count;

  // The skid register only fills behind a full output register.
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid register holds a result while the output is empty");

  // The skid register fills only while the receiver stalls.
  a_skid_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(out_valid_q && out_stall_i))
    else $error("skid register filled without a stall");

  // The end marker leaves the decoder in its initial state.
  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && req_type_i == sdec_pkg::REQ_END) |=>
      (fill_q == 2'd0 && !esc_q && count_q == '0 && err_q == sdec_pkg::ST_OK))
    else $error("decoder state not cleared after end of body");

  // A body transfer never takes the decoded count past the limit.
  a_count_in_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && req_type_i == sdec_pkg::REQ_BODY && count_q <= limit_q) |=>
      (count_q <= limit_q))
    else $error("decoded byte count exceeds the limit");

endmodule

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// Testbench for the six-bit text to binary decoder
// Streams encoded body text and end markers into the decoder, predicts every
// decoded group, NUL run and final status in step with the input transfers,
// and checks each result transfer field by field against the oldest
// prediction. Phases change the decoded size limit and the idling pattern on
// both channels.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TimeoutCycles = 400000;
  localparam int unsigned NumPhases     = 8;
  localparam int unsigned ItemsPerPhase = 230;
  localparam int unsigned DrainCycles   = 6;

  // One encoded character or end-of-body marker waiting to be sent.
  typedef struct {
    sdec_pkg::req_e req;
    logic [7:0]     ch;
  } text_item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [28:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        req_type_i = 1'b0;
  logic [7:0]  byte_value_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  kind_o;
  logic [7:0]  byte_high_o;
  logic [7:0]  byte_mid_o;
  logic [7:0]  byte_low_o;
  logic [6:0]  run_length_o;
  logic [2:0]  status_o;
  logic [28:0] raw_size_o;
  logic [1:0]  strip_count_o;

  six_bit_text_to_binary_decoder i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .req_type_i    (req_type_i),
    .byte_value_i  (byte_value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .kind_o        (kind_o),
    .byte_high_o   (byte_high_o),
    .byte_mid_o    (byte_mid_o),
    .byte_low_o    (byte_low_o),
    .run_length_o  (run_length_o),
    .status_o      (status_o),
    .raw_size_o    (raw_size_o),
    .strip_count_o (strip_count_o)
  );

  // Clock generation.
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  text_item_t         text_q[$];
  sdec_pkg::result_t  decoded_q[$];
  logic               in_taken = 1'b0;
  int unsigned        send_gap_pct = 0;
  int unsigned        stall_pct = 0;
  int unsigned        fail_count = 0;
  int unsigned        n_in = 0;
  int unsigned        n_out = 0;
  int unsigned        queued_items = 0;
  int unsigned        cycle_count = 0;

  // Predicted decoder state and the limit register.
  logic [28:0]        size_limit = sdec_pkg::LimitReset;
  logic [1:0]         grp_fill = '0;
  logic [5:0]         grp_vals [3];
  logic               esc_pend = 1'b0;
  logic [28:0]        out_count = '0;
  logic [1:0]         nul_tail = '0;
  sdec_pkg::status_e  body_err = sdec_pkg::ST_OK;

  // Advance the predicted state by one accepted item and queue any result.
  task automatic decode_step(input sdec_pkg::req_e req, input logic [7:0] ch);
    sdec_pkg::result_t r;
    logic [6:0]        n;
    logic [5:0]        v3;
    int unsigned       tail;
    r = '0;
    if (req == sdec_pkg::REQ_END) begin
      r.kind   = sdec_pkg::KIND_STATUS;
      r.status = body_err;
      if (body_err == sdec_pkg::ST_OK) begin
        if (esc_pend || grp_fill != 2'd0) begin
          r.status = sdec_pkg::ST_TRUNC;
        end else if (out_count <= 29'(nul_tail)) begin
          r.status = sdec_pkg::ST_EMPTY;
        end else begin
          r.raw_size    = out_count;
          r.strip_count = nul_tail;
        end
      end
      decoded_q.push_back(r);
      grp_fill  = '0;
      esc_pend  = 1'b0;
      out_count = '0;
      nul_tail  = '0;
      body_err  = sdec_pkg::ST_OK;
      return;
    end
    // A sticky error swallows the rest of the body.
    if (body_err != sdec_pkg::ST_OK) return;
    if (ch == sdec_pkg::ChLf || ch == sdec_pkg::ChCr) begin
      if (esc_pend) body_err = sdec_pkg::ST_ESCBREAK;
      return;
    end
    // Count character after an escape.
    if (esc_pend) begin
      esc_pend = 1'b0;
      if (ch < sdec_pkg::AlphaLo || ch > sdec_pkg::CountHi) begin
        body_err = sdec_pkg::ST_BADCOUNT;
        return;
      end
      n = 7'(ch - sdec_pkg::AlphaLo);
      if (n == 7'd0) return;
      if (30'(out_count) + 30'(n) > 30'(size_limit)) begin
        body_err = sdec_pkg::ST_LIMIT;
        return;
      end
      out_count    = out_count + 29'(n);
      tail         = nul_tail + n;
      nul_tail     = (tail > 2) ? 2'd2 : 2'(tail);
      r.kind       = sdec_pkg::KIND_RUN;
      r.run_length = n;
      decoded_q.push_back(r);
      return;
    end
    if (ch == sdec_pkg::ChEsc) begin
      esc_pend = 1'b1;
      return;
    end
    if (ch < sdec_pkg::AlphaLo || ch > sdec_pkg::AlphaHi) begin
      body_err = sdec_pkg::ST_BADCHAR;
      return;
    end
    if (grp_fill < 2'd3) begin
      grp_vals[grp_fill] = 6'(ch - sdec_pkg::AlphaLo);
      grp_fill++;
      return;
    end
    // Fourth character completes the group.
    grp_fill = '0;
    if (30'(out_count) + 30'd3 > 30'(size_limit)) begin
      body_err = sdec_pkg::ST_LIMIT;
      return;
    end
    v3          = 6'(ch - sdec_pkg::AlphaLo);
    r.kind      = sdec_pkg::KIND_GROUP;
    r.byte_high = {grp_vals[0], grp_vals[1][5:4]};
    r.byte_mid  = {grp_vals[1][3:0], grp_vals[2][5:2]};
    r.byte_low  = {grp_vals[2][1:0], v3};
    out_count   = out_count + 29'd3;
    if (r.byte_low != 8'd0) nul_tail = 2'd0;
    else if (r.byte_mid != 8'd0) nul_tail = 2'd1;
    else nul_tail = 2'd2;
    decoded_q.push_back(r);
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endtask

  // Driver: presents the next pending item at the falling edge and holds it
  // until the transfer completes.
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (text_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
        in_valid_i   <= 1'b1;
        req_type_i   <= text_q[0].req;
        byte_value_i <= text_q[0].ch;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver back-pressure.
  always @(negedge clk_i) begin
    out_stall_i <= rst_ni && ($urandom_range(99) < stall_pct);
  end

  // Monitor: checks result transfers, then predicts from input transfers.
  always @(posedge clk_i) begin
    sdec_pkg::result_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        n_out++;
        if (decoded_q.size() == 0) begin
          $error("Unexpected result transfer: kind %0d status %0d", kind_o, status_o);
          fail_count++;
        end else begin
          want = decoded_q.pop_front();
          check_field("kind", want.kind, kind_o);
          check_field("byte_high", want.byte_high, byte_high_o);
          check_field("byte_mid", want.byte_mid, byte_mid_o);
          check_field("byte_low", want.byte_low, byte_low_o);
          check_field("run_length", want.run_length, run_length_o);
          check_field("status", want.status, status_o);
          check_field("raw_size", want.raw_size, raw_size_o);
          check_field("strip_count", want.strip_count, strip_count_o);
        end
      end
      in_taken <= in_valid_i && !in_stall_o;
      if (in_valid_i && !in_stall_o) begin
        n_in++;
        void'(text_q.pop_front());
        decode_step(sdec_pkg::req_e'(req_type_i), byte_value_i);
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > TimeoutCycles) begin
      $error("Timed out with %0d items and %0d results outstanding",
             text_q.size(), decoded_q.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic put(input logic [7:0] ch);
    queued_items++;
    text_q.push_back('{sdec_pkg::REQ_BODY, ch});
  endtask

  task automatic put_end();
    queued_items++;
    text_q.push_back('{sdec_pkg::REQ_END, 8'h00});
  endtask

  task automatic put_str(input string s);
    for (int i = 0; i < s.len(); i++) put(s[i]);
  endtask

  // Alphabet character, biased toward zero so that NUL bytes show up.
  function automatic logic [7:0] rand_alpha();
    if ($urandom_range(3) == 0) return sdec_pkg::AlphaLo;
    return 8'($urandom_range(sdec_pkg::AlphaLo, sdec_pkg::AlphaHi));
  endfunction

  // One body of random content followed by its end marker. Most tokens are
  // well formed; a few are noise or broken escapes and partial groups.
  task automatic add_random_body();
    int unsigned tokens;
    int unsigned pick;
    tokens = ($urandom_range(9) == 0) ? $urandom_range(12, 30) : $urandom_range(0, 6);
    for (int t = 0; t < tokens; t++) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        repeat (4) put(rand_alpha());
      end else if (pick < 70) begin
        put(sdec_pkg::ChEsc);
        if ($urandom_range(2) == 0) put(8'($urandom_range(8'h30, 8'h33)));
        else put(8'($urandom_range(sdec_pkg::AlphaLo, sdec_pkg::CountHi)));
      end else if (pick < 80) begin
        put($urandom_range(1) ? sdec_pkg::ChCr : sdec_pkg::ChLf);
      end else if (pick < 86) begin
        put(8'($urandom_range(255)));
      end else if (pick < 89) begin
        put(sdec_pkg::ChEsc);
        put($urandom_range(1) ? sdec_pkg::ChCr : sdec_pkg::ChLf);
      end else if (pick < 94) begin
        repeat ($urandom_range(1, 3)) put(rand_alpha());
      end else begin
        put(sdec_pkg::ChEsc);
        if ($urandom_range(1)) put(8'($urandom_range(255)));
      end
    end
    put_end();
  endtask

  // Wait until every item is sent and every result checked, then let the
  // pipeline drain.
  task automatic settle();
    while (text_q.size() != 0 || decoded_q.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_limit(input logic [28:0] value);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    size_limit  = value;
  endtask

  // Stimulus sequencing.
  initial begin
    logic [28:0] phase_limit [NumPhases];
    int unsigned target;
    phase_limit = '{sdec_pkg::LimitReset, 29'd1, 29'd4, sdec_pkg::LimitReset, 29'd30,
                    29'd2, 29'd150, sdec_pkg::LimitReset};
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    for (int phase = 0; phase < NumPhases; phase++) begin
      if (phase > 0) begin
        settle();
        write_limit(phase_limit[phase]);
      end
      // Idling pattern: none, sender gaps, receiver stalls, then both.
      case (phase % 4)
        0: begin send_gap_pct = 0;  stall_pct = 0;  end
        1: begin send_gap_pct = 65; stall_pct = 0;  end
        2: begin send_gap_pct = 0;  stall_pct = 65; end
        default: begin send_gap_pct = 13; stall_pct = 13; end
      endcase
      if (phase == 0) begin
        // Extreme groups, skipped line breaks, zero and longest runs.
        put_str("0000oooo");
        put(sdec_pkg::ChCr);
        put(sdec_pkg::ChLf);
        put_str("~0");
        put(sdec_pkg::ChEsc);
        put(sdec_pkg::CountHi);
        put_end();
        // Empty body, and a body made only of pad bytes.
        put_end();
        put_str("~2");
        put_end();
        // Partial group at the end.
        put_str("A");
        put_end();
        // Line break inside an escape, with later text ignored.
        put(sdec_pkg::ChEsc);
        put(sdec_pkg::ChLf);
        put_str("00");
        put_end();
        // Count character out of range, and a bad character.
        put(sdec_pkg::ChEsc);
        put(8'h7f);
        put_end();
        put(8'hff);
        put_end();
      end else if (phase == 1) begin
        // With a limit of one byte: a group overflows, a single NUL is all pad,
        // and a two-byte run overflows.
        put_str("0000");
        put_end();
        put_str("~1");
        put_end();
        put_str("~2");
        put_end();
      end
      target = queued_items + ItemsPerPhase;
      while (queued_items < target) begin
        add_random_body();
        while (text_q.size() > 16) @(negedge clk_i);
      end
    end
    settle();
    $display("Covered %0d input transfers and %0d result transfers over %0d phases",
             n_in, n_out, NumPhases);
    $display("of limit and idling settings, with %0d mismatches.", fail_count);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/sdec_pkg.sv
rtl/six_bit_text_to_binary_decoder.sv
bench/tb.sv
